@@ design/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int NUM_DIGITS = 32;   // binary needs 32 digit slots
  localparam int BCD_DIGITS = 20;   // enough for 2^64 - 1 in decimal
  localparam int DIGIT_W    = 4;
  localparam int PTR_W      = $clog2(NUM_DIGITS);
  localparam int ITER_W     = 7;    // holds 64 iterations

  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_A     = 7'h41;
  localparam logic [6:0] ASCII_MINUS = 7'h2d;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_buf_t;

  // Setup handed from the operand unpacker to the sequencer.
  typedef struct packed {
    logic              neg;
    logic              decimal;
    logic [PTR_W-1:0]  top;
    logic [ITER_W-1:0] iters;
    logic [63:0]       bin;
    digit_buf_t        digits;
  } itoa_setup_t;

  function automatic logic [6:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d < 4'd10) begin
      return ASCII_ZERO + {3'b000, d};
    end else begin
      return ASCII_A + {3'b000, d} - 7'd10;
    end
  endfunction

endpackage

@@ design/itoa_unpack.sv @@
// ----------------------------------------------------------------------------
// itoa_unpack
// Sign handling and magnitude selection; splits binary, octal and hex
// operands straight into digit slots, and sets up the decimal conversion.
// ----------------------------------------------------------------------------
module itoa_unpack
  import itoa_pkg::*;
(
  input  logic [63:0]  value,
  input  logic [1:0]   req_type,
  input  logic         is_signed,
  input  logic         is_64bit,
  output itoa_setup_t  setup
);

  logic        wide;
  logic        neg;
  logic [63:0] mag;
  logic [31:0] mag32;
  logic [34:0] mag35;

  always_comb begin
    wide  = is_64bit && (req_type == RADIX_DEC);
    neg   = 1'b0;
    mag32 = value[31:0];
    mag   = value;
    if (wide) begin
      neg = is_signed && value[63];
      if (neg) mag = 64'd0 - value;
    end else begin
      neg = is_signed && value[31];
      if (neg) mag32 = 32'd0 - value[31:0];
      mag = {32'd0, mag32};
    end
    mag35 = {3'b000, mag[31:0]};

    setup.neg     = neg;
    setup.decimal = (req_type == RADIX_DEC);
    setup.iters   = wide ? ITER_W'(64) : ITER_W'(32);
    setup.bin     = wide ? mag : {mag[31:0], 32'd0};
    setup.digits  = '0;
    setup.top     = '0;

    unique case (req_type)
      RADIX_BIN: begin
        for (int i = 0; i < NUM_DIGITS; i++) setup.digits[i] = {3'b000, mag[i]};
        setup.top = PTR_W'(31);
      end
      RADIX_OCT: begin
        for (int i = 0; i < 11; i++) setup.digits[i] = {1'b0, mag35[3*i +: 3]};
        setup.top = PTR_W'(10);
      end
      RADIX_DEC: begin
        setup.top = wide ? PTR_W'(BCD_DIGITS - 1) : PTR_W'(9);
      end
      RADIX_HEX: begin
        for (int i = 0; i < 8; i++) setup.digits[i] = mag[4*i +: 4];
        setup.top = PTR_W'(7);
      end
      default: setup.top = '0;
    endcase
  end

endmodule

@@ design/itoa_dabble.sv @@
// ----------------------------------------------------------------------------
// itoa_dabble
// One shift-and-add-3 step of binary to BCD conversion over the low
// BCD digit slots; the sequencer runs it once per operand bit.
// ----------------------------------------------------------------------------
module itoa_dabble
  import itoa_pkg::*;
(
  input  digit_buf_t  digits,
  input  logic [63:0] bin,
  output digit_buf_t  digits_next,
  output logic [63:0] bin_next
);

  logic [BCD_DIGITS-1:0][DIGIT_W-1:0] adj;
  logic [BCD_DIGITS*DIGIT_W-1:0]      shifted;

  always_comb begin
    for (int j = 0; j < BCD_DIGITS; j++) begin
      adj[j] = (digits[j] >= 4'd5) ? digits[j] + 4'd3 : digits[j];
    end
    // top bit of adj is never set: 20 digits cover the full 64-bit range
    shifted = {adj[BCD_DIGITS-1][DIGIT_W-2:0], adj[BCD_DIGITS-2:0], bin[63]};
    digits_next = '0;
    for (int j = 0; j < BCD_DIGITS; j++) begin
      digits_next[j] = shifted[DIGIT_W*j +: DIGIT_W];
    end
    bin_next = {bin[62:0], 1'b0};
  end

endmodule

@@ design/integer_to_ascii_radix.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Integer to ASCII text, most significant character first, one beat each.
// Binary/octal/hex digits load straight from the unpacker; decimal runs
// 32 (or 64 for a 64-bit operand) dabble steps through one shared
// add-3/shift unit. Then leading zero slots are skipped, the first
// character is picked, then one beat per character while out_ready is high.
// One item at a time: ready only when the previous string is fully sent.
// Synchronous reset returns the sequencer to idle; no other state.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix
  import itoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value,
  input  logic [1:0]  req_type,
  input  logic        is_signed,
  input  logic        is_64bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  char_code,
  output logic [5:0]  char_index,
  output logic        last
);

  typedef enum logic [2:0] {ST_IDLE, ST_CONV, ST_SCAN, ST_SIGN, ST_EMIT} state_t;

  state_t            state;
  digit_buf_t        digits;
  logic [63:0]       bin;
  logic              neg;
  logic [PTR_W-1:0]  ptr;
  logic [ITER_W-1:0] cnt;
  logic [5:0]        idx;

  itoa_setup_t       setup;
  digit_buf_t        digits_next;
  logic [63:0]       bin_next;
  logic [DIGIT_W-1:0] cur;

  itoa_unpack u_unpack (
    .value     (value),
    .req_type  (req_type),
    .is_signed (is_signed),
    .is_64bit  (is_64bit),
    .setup     (setup)
  );

  itoa_dabble u_dabble (
    .digits      (digits),
    .bin         (bin),
    .digits_next (digits_next),
    .bin_next    (bin_next)
  );

  assign cur        = digits[ptr];
  assign in_ready   = (state == ST_IDLE);
  assign out_valid  = (state == ST_SIGN) || (state == ST_EMIT);
  assign char_code  = (state == ST_SIGN) ? ASCII_MINUS : digit_char(cur);
  assign char_index = idx;
  assign last       = (state == ST_EMIT) && (ptr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            digits <= setup.digits;
            bin    <= setup.bin;
            neg    <= setup.neg;
            ptr    <= setup.top;
            cnt    <= setup.iters;
            idx    <= '0;
            state  <= setup.decimal ? ST_CONV : ST_SCAN;
          end
        end
        ST_CONV: begin
          digits <= digits_next;
          bin    <= bin_next;
          cnt    <= cnt - ITER_W'(1);
          if (cnt == ITER_W'(1)) state <= ST_SCAN;
        end
        ST_SCAN: begin
          // drop leading zeros, keeping at least one digit
          if ((ptr != '0) && (cur == '0)) begin
            ptr <= ptr - PTR_W'(1);
          end else begin
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (out_ready) begin
            idx   <= 6'd1;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (ptr == '0) begin
              state <= ST_IDLE;
            end else begin
              ptr <= ptr - PTR_W'(1);
              idx <= idx + 6'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("sequencer did not return to idle after last beat");

  a_string_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> (out_valid && char_index == $past(char_index) + 6'd1))
    else $error("character string broken mid-item");

  a_conv_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> (cnt != '0))
    else $error("dabble iteration count underflow");

endmodule
